>>> rtl/core/cwpg_pkg.sv
// cwpg_pkg: shared types, constants and the raised-cosine weight table builder
// for the circular window pixel generator.
// No dependencies.
package cwpg_pkg;

  localparam int MAX_SIDE   = 4096;
  localparam int FRAC_BITS  = 16;
  localparam int COS_DEPTH  = 1024;

  localparam int SIDE_W     = 13;
  localparam int DIAM_W     = 14;
  localparam int KIND_W     = 3;
  localparam int VALUE_W    = 17;
  localparam int OFS_W      = SIDE_W + 1;
  localparam int SQ_W       = 2 * OFS_W;
  localparam int SQRT_PAIRS = 20;
  localparam int S_EXT_W    = 2 * SQRT_PAIRS;
  localparam int ROOT_STEPS = SQRT_PAIRS + FRAC_BITS;
  localparam int ROOT_W     = 32;
  localparam int REM_W      = ROOT_W + 2;
  localparam int N2_W       = DIAM_W + FRAC_BITS;
  localparam int NUM_W      = 32;
  localparam int DEN_W      = DIAM_W + 7;
  localparam int QUO_W      = VALUE_W;
  localparam int K_W        = $clog2(COS_DEPTH + 1);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = DIAM_W;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIAMETER     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_KIND  = 2'd3;

  localparam logic [KIND_W-1:0] KIND_RECT     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_BARTLETT = 3'd1;
  localparam logic [KIND_W-1:0] KIND_HAMMING  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_HANN     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TRIANGLE = 3'd4;

  localparam logic [SIDE_W-1:0]  SIDE_MAX  = SIDE_W'(MAX_SIDE);
  localparam logic [VALUE_W-1:0] VALUE_ONE = VALUE_W'(65536);

  localparam longint unsigned Q30_ONE = 64'd1073741824;
  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint unsigned WT_DEN  = 64'd100 * Q30_ONE;

  // taylor step divisors (2j)(2j-1)
  localparam longint unsigned TAYLOR_DEN [1:7] = '{64'd2, 64'd12, 64'd30, 64'd56,
                                                   64'd90, 64'd132, 64'd182};

  typedef struct packed {
    logic [SIDE_W-1:0] image_width;
    logic [SIDE_W-1:0] image_height;
    logic [DIAM_W-1:0] diameter;
    logic [KIND_W-1:0] window_kind;
  } cfg_t;

  typedef struct packed {
    logic [SIDE_W-1:0] col;
    logic [SIDE_W-1:0] row;
  } pixel_t;

  typedef struct packed {
    logic [VALUE_W-1:0] window_value;
    logic               inside_res;
    logic               bad_kind;
  } weight_t;

  typedef struct packed {
    logic [OFS_W-1:0] dx2;
    logic [OFS_W-1:0] dy2;
    logic             bad;
  } qitem_t;

  typedef logic [VALUE_W-1:0] wtab_t [0:COS_DEPTH];

  // weight per table index: hann selects 0.5/0.5, otherwise 0.54/0.46
  function automatic wtab_t build_tab(input logic hann);
    wtab_t tab;
    longint unsigned k, x, x2, t, p, v, d, base, weight, q;
    logic neg;
    int i, j;
    base   = hann ? 64'd50 : 64'd54;
    weight = hann ? 64'd50 : 64'd46;
    for (i = 0; i <= COS_DEPTH; i++) begin
      k   = longint'(i);
      neg = 1'b0;
      if (2 * k > COS_DEPTH) begin
        k   = COS_DEPTH - k;
        neg = 1'b1;
      end
      x  = (k * PI_Q30 + COS_DEPTH / 2) / COS_DEPTH;
      x2 = (x * x + (Q30_ONE / 2)) >> 30;
      t  = Q30_ONE;
      for (j = 7; j >= 1; j--) begin
        p = ((x2 * t) >> 30) / TAYLOR_DEN[j];
        t = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
      end
      v = base * Q30_ONE;
      d = weight * t;
      if (neg) begin
        v = v + d;
      end else begin
        v = (v > d) ? v - d : 64'd0;
      end
      q = (v * 64'd65536 + WT_DEN / 2) / WT_DEN;
      if (q > 64'd65536) begin
        q = 64'd65536;
      end
      tab[i] = VALUE_W'(q);
    end
    return tab;
  endfunction

endpackage

>>> rtl/core/cwpg_front.sv
// cwpg_front: accepts pixels, saturates coordinates and forms the doubled
// offsets from the image center plus the window kind check.
// Depends on cwpg_pkg.
module cwpg_front (
  input  cwpg_pkg::cfg_t   cfg,
  input  logic             pixel_valid,
  input  cwpg_pkg::pixel_t pixel,
  output logic             pixel_ready,
  input  logic             q_full,
  output logic             push,
  output cwpg_pkg::qitem_t push_item
);
  import cwpg_pkg::*;

  function automatic logic [SIDE_W-1:0] sat_side(input logic [SIDE_W-1:0] v);
    return (v > SIDE_MAX) ? SIDE_MAX : v;
  endfunction

  // |2*pos - (side+1)|
  function automatic logic [OFS_W-1:0] doubled_offset(input logic [SIDE_W-1:0] pos,
                                                      input logic [SIDE_W-1:0] side);
    logic [OFS_W-1:0] a;
    logic [OFS_W-1:0] b;
    a = {pos, 1'b0};
    b = {1'b0, side} + OFS_W'(1);
    return (a >= b) ? a - b : b - a;
  endfunction

  assign pixel_ready = !q_full;
  assign push        = pixel_valid && !q_full;

  always_comb begin
    push_item.dx2 = doubled_offset(sat_side(pixel.col), sat_side(cfg.image_width));
    push_item.dy2 = doubled_offset(sat_side(pixel.row), sat_side(cfg.image_height));
    push_item.bad = cfg.window_kind > KIND_TRIANGLE;
  end

endmodule

>>> rtl/core/cwpg_queue.sv
// cwpg_queue: small first-in first-out queue between front and back.
// Depends on cwpg_pkg.
module cwpg_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  cwpg_pkg::qitem_t push_item,
  output logic             full,
  input  logic             pop,
  output logic             pop_valid,
  output cwpg_pkg::qitem_t pop_item
);
  import cwpg_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int PTR_W = $clog2(DEPTH);

  qitem_t             mem [0:DEPTH-1];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_pop;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full      = (count == CNT_W'(DEPTH));
  assign pop_valid = (count != '0);
  assign do_pop    = pop && pop_valid;
  assign pop_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= next_ptr(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= next_ptr(rd_ptr);
      end
      case ({push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

>>> rtl/core/cwpg_back.sv
// cwpg_back: pipelined radius, digit-by-digit square root, restoring
// divider, weight table lookup and output register.
// Depends on cwpg_pkg.
module cwpg_back (
  input  logic              clk,
  input  logic              rst,
  input  cwpg_pkg::cfg_t    cfg,
  input  logic              q_valid,
  input  cwpg_pkg::qitem_t  q_item,
  output logic              pop,
  output logic              weight_valid,
  input  logic              weight_ready,
  output cwpg_pkg::weight_t weight
);
  import cwpg_pkg::*;

  localparam int CMP_W = DEN_W + QUO_W;
  localparam wtab_t HAMMING_TAB = build_tab(1'b0);
  localparam wtab_t HANN_TAB    = build_tab(1'b1);

  logic              adv;
  logic [DIAM_W-1:0] diam;
  logic [DIAM_W-1:0] m_val;
  logic [DIAM_W:0]   b_val;
  logic [SQ_W-1:0]   mm;

  // whole pipe moves together, stalls only when the output is held
  assign adv = !weight_valid || weight_ready;
  assign pop = q_valid && adv;

  assign diam  = (cfg.diameter < DIAM_W'(2)) ? DIAM_W'(2) : cfg.diameter;
  assign m_val = diam - DIAM_W'(1);
  assign b_val = {1'b0, diam} + (DIAM_W + 1)'(1);

  always_ff @(posedge clk) begin
    mm <= m_val * m_val;
  end

  // squares
  logic            v0;
  logic [SQ_W-1:0] sqx;
  logic [SQ_W-1:0] sqy;
  logic            bad0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sqx  <= q_item.dx2 * q_item.dx2;
      sqy  <= q_item.dy2 * q_item.dy2;
      bad0 <= q_item.bad;
    end
  end

  // sum and circle test
  logic               v1;
  logic [S_EXT_W-1:0] s1;
  logic               in1;
  logic               bad1;
  logic [SQ_W:0]      sum;

  assign sum = {1'b0, sqx} + {1'b0, sqy};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1   <= S_EXT_W'(sum);
      in1  <= sum <= {1'b0, mm};
      bad1 <= bad0;
    end
  end

  // square root, one result bit per stage
  logic               sv_p   [0:ROOT_STEPS];
  logic [S_EXT_W-1:0] s_p    [0:ROOT_STEPS];
  logic [REM_W-1:0]   rem_p  [0:ROOT_STEPS];
  logic [ROOT_W-1:0]  root_p [0:ROOT_STEPS];
  logic               in_p   [0:ROOT_STEPS];
  logic               bad_p  [0:ROOT_STEPS];

  assign sv_p[0]   = v1;
  assign s_p[0]    = s1;
  assign rem_p[0]  = '0;
  assign root_p[0] = '0;
  assign in_p[0]   = in1;
  assign bad_p[0]  = bad1;

  for (genvar g = 0; g < ROOT_STEPS; g++) begin : g_sqrt
    localparam int I = ROOT_STEPS - 1 - g;
    logic [1:0]       pair;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;

    if (I >= FRAC_BITS) begin : g_pair
      assign pair = s_p[g][2*(I-FRAC_BITS) +: 2];
    end else begin : g_frac
      assign pair = 2'b00;
    end

    assign rem_sh = {rem_p[g][REM_W-3:0], pair};
    assign trial  = {root_p[g], 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        sv_p[g+1] <= 1'b0;
      end else if (adv) begin
        sv_p[g+1] <= sv_p[g];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        s_p[g+1]   <= s_p[g];
        in_p[g+1]  <= in_p[g];
        bad_p[g+1] <= bad_p[g];
        if (rem_sh >= trial) begin
          rem_p[g+1]  <= rem_sh - trial;
          root_p[g+1] <= {root_p[g][ROOT_W-2:0], 1'b1};
        end else begin
          rem_p[g+1]  <= rem_sh;
          root_p[g+1] <= {root_p[g][ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  // distance into the window and divider operands
  logic [N2_W-1:0]  m_sh;
  logic [N2_W-1:0]  n2;
  logic [NUM_W-1:0] a_val;
  logic [NUM_W-1:0] num;
  logic [DEN_W-1:0] den;

  assign m_sh  = {m_val, FRAC_BITS'(0)};
  assign n2    = in_p[ROOT_STEPS] ? m_sh - root_p[ROOT_STEPS][N2_W-1:0] : '0;
  assign a_val = NUM_W'(n2) + NUM_W'(2 ** (FRAC_BITS + 1));

  // rounded quotients reduced to floor((2a + b) / 2b) forms
  always_comb begin
    case (cfg.window_kind)
      KIND_BARTLETT: begin
        num = NUM_W'({n2, 1'b0}) + NUM_W'(m_val);
        den = DEN_W'({m_val, 1'b0});
      end
      KIND_HAMMING: begin
        num = NUM_W'(n2) + NUM_W'({m_val, 5'b0});
        den = DEN_W'({m_val, 6'b0});
      end
      KIND_HANN: begin
        num = a_val + NUM_W'({b_val, 5'b0});
        den = DEN_W'({b_val, 6'b0});
      end
      KIND_TRIANGLE: begin
        num = {a_val[NUM_W-2:0], 1'b0} + NUM_W'(b_val);
        den = DEN_W'({b_val, 1'b0});
      end
      default: begin
        num = '0;
        den = DEN_W'(1);
      end
    endcase
  end

  logic             dv_p   [0:QUO_W];
  logic [NUM_W-1:0] drem_p [0:QUO_W];
  logic [DEN_W-1:0] dden_p [0:QUO_W];
  logic [QUO_W-1:0] dquo_p [0:QUO_W];
  logic             din_p  [0:QUO_W];
  logic             dbad_p [0:QUO_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_p[0] <= 1'b0;
    end else if (adv) begin
      dv_p[0] <= sv_p[ROOT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      drem_p[0] <= num;
      dden_p[0] <= den;
      dquo_p[0] <= '0;
      din_p[0]  <= in_p[ROOT_STEPS];
      dbad_p[0] <= bad_p[ROOT_STEPS];
    end
  end

  // restoring divider, one quotient bit per stage, msb first
  for (genvar j = 0; j < QUO_W; j++) begin : g_div
    localparam int B = QUO_W - 1 - j;
    logic [CMP_W-1:0] shifted;
    logic [CMP_W-1:0] rem_ext;

    assign shifted = CMP_W'(dden_p[j]) << B;
    assign rem_ext = CMP_W'(drem_p[j]);

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_p[j+1] <= 1'b0;
      end else if (adv) begin
        dv_p[j+1] <= dv_p[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dden_p[j+1] <= dden_p[j];
        din_p[j+1]  <= din_p[j];
        dbad_p[j+1] <= dbad_p[j];
        if (rem_ext >= shifted) begin
          drem_p[j+1] <= NUM_W'(rem_ext - shifted);
          dquo_p[j+1] <= dquo_p[j] | (QUO_W'(1) << B);
        end else begin
          drem_p[j+1] <= drem_p[j];
          dquo_p[j+1] <= dquo_p[j];
        end
      end
    end
  end

  // weight table lookup
  logic [K_W-1:0]     k_idx;
  logic               tv;
  logic [QUO_W-1:0]   t_quo;
  logic               t_in;
  logic               t_bad;
  logic [VALUE_W-1:0] ham_r;
  logic [VALUE_W-1:0] hann_r;

  assign k_idx = (dquo_p[QUO_W] > QUO_W'(COS_DEPTH)) ? K_W'(COS_DEPTH)
                                                     : dquo_p[QUO_W][K_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      tv <= 1'b0;
    end else if (adv) begin
      tv <= dv_p[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t_quo  <= dquo_p[QUO_W];
      t_in   <= din_p[QUO_W];
      t_bad  <= dbad_p[QUO_W];
      ham_r  <= HAMMING_TAB[k_idx];
      hann_r <= HANN_TAB[k_idx];
    end
  end

  // final selection and output register
  logic [VALUE_W-1:0] raw;
  logic [VALUE_W-1:0] value;

  always_comb begin
    case (cfg.window_kind)
      KIND_RECT:     raw = VALUE_ONE;
      KIND_BARTLETT: raw = t_quo;
      KIND_HAMMING:  raw = ham_r;
      KIND_HANN:     raw = hann_r;
      KIND_TRIANGLE: raw = t_quo;
      default:       raw = '0;
    endcase
    if (!t_in || t_bad) begin
      value = '0;
    end else if (raw > VALUE_ONE) begin
      value = VALUE_ONE;
    end else begin
      value = raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      weight_valid <= 1'b0;
    end else if (adv) begin
      weight_valid <= tv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      weight.window_value <= value;
      weight.inside_res   <= t_in;
      weight.bad_kind     <= t_bad;
    end
  end

endmodule

>>> rtl/core/circular_window_pixel_generator.sv
// Circular window pixel generator: for each 1-based pixel (col,row) it gives
// the weight of a circularly symmetric window (rectangle, Bartlett, Hamming,
// Hann or triangle) centered on the image, as unsigned Q1.16, zero outside
// the circle. One pixel is taken and one weight delivered per cycle while the
// queue is not full and the output is not held; a pixel's weight passes
// through the queue slot, two square and sum stages, the 36-stage square
// root, the 18-stage divider, the table lookup and the output register.
// The front queue of QUEUE_DEPTH entries lets input keep flowing briefly
// while the output is stalled. Registers are written through wr_en,
// wr_index and wr_data and must only change while no pixel is in flight.
module circular_window_pixel_generator #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_en,
  input  logic [cwpg_pkg::CFG_IDX_W-1:0]     wr_index,
  input  logic [cwpg_pkg::CFG_DATA_W-1:0]    wr_data,
  input  logic                               pixel_valid,
  output logic                               pixel_ready,
  input  cwpg_pkg::pixel_t                   pixel,
  output logic                               weight_valid,
  input  logic                               weight_ready,
  output cwpg_pkg::weight_t                  weight
);
  import cwpg_pkg::*;

  cfg_t   cfg;
  logic   q_full;
  logic   push;
  qitem_t push_item;
  logic   pop;
  logic   pop_valid;
  qitem_t pop_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width  <= SIDE_W'(512);
      cfg.image_height <= SIDE_W'(512);
      cfg.diameter     <= DIAM_W'(512);
      cfg.window_kind  <= KIND_HAMMING;
    end else if (wr_en) begin
      case (wr_index)
        CFG_IMAGE_WIDTH:  cfg.image_width  <= wr_data[SIDE_W-1:0];
        CFG_IMAGE_HEIGHT: cfg.image_height <= wr_data[SIDE_W-1:0];
        CFG_DIAMETER:     cfg.diameter     <= wr_data[DIAM_W-1:0];
        CFG_WINDOW_KIND:  cfg.window_kind  <= wr_data[KIND_W-1:0];
        default:          cfg              <= cfg;
      endcase
    end
  end

  cwpg_front u_front (
    .cfg         (cfg),
    .pixel_valid (pixel_valid),
    .pixel       (pixel),
    .pixel_ready (pixel_ready),
    .q_full      (q_full),
    .push        (push),
    .push_item   (push_item)
  );

  cwpg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_item  (pop_item)
  );

  cwpg_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (pop_valid),
    .q_item       (pop_item),
    .pop          (pop),
    .weight_valid (weight_valid),
    .weight_ready (weight_ready),
    .weight       (weight)
  );

endmodule

>>> verif/tb_top.sv
// tb_top: self-checking bench for circular_window_pixel_generator.
// Drives pixels through valid/ready and checks each weight against its own predictor or a known answer.
// Depends on cwpg_pkg and the circular_window_pixel_generator rtl.
`timescale 1ns / 1ps

module tb_top;
  import cwpg_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DIR_ROWS = 20;
  localparam int RAND_PHASES = 9;
  localparam int PHASE_ITEMS = 100;

  typedef struct {
    cfg_t    c;
    pixel_t  p;
    bit      typed;
    weight_t w;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] wr_index = '0;
  logic [CFG_DATA_W-1:0] wr_data = '0;
  logic pixel_valid = 1'b0;
  logic pixel_ready;
  pixel_t pixel = '0;
  logic weight_valid;
  logic weight_ready = 1'b0;
  weight_t weight;

  cfg_t cur_cfg;
  weight_t exp_weights[$];
  int send_idle_pct;
  int recv_idle_pct;
  int mismatches;
  int quiet_cycles;

  circular_window_pixel_generator dut (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .pixel_valid(pixel_valid), .pixel_ready(pixel_ready), .pixel(pixel),
    .weight_valid(weight_valid), .weight_ready(weight_ready), .weight(weight)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint unsigned clamp_side(longint unsigned v);
    return (v > MAX_SIDE) ? longint'(MAX_SIDE) : v;
  endfunction

  function automatic longint unsigned half_offset(longint unsigned pos, longint unsigned side);
    longint unsigned a, b;
    a = 2 * pos;
    b = side + 1;
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic longint unsigned rdiv(longint unsigned num, longint unsigned den);
    return (num + den / 2) / den;
  endfunction

  // digit-by-digit root, result carries FRAC_BITS fraction bits
  function automatic longint unsigned radius_q16(longint unsigned s);
    longint unsigned root, rem, trial, pair;
    int i;
    root = 0;
    rem = 0;
    for (i = SQRT_PAIRS + FRAC_BITS - 1; i >= 0; i--) begin
      pair = (i >= FRAC_BITS) ? ((s >> (2 * (i - FRAC_BITS))) & 3) : 0;
      rem = (rem << 2) | pair;
      trial = (root << 2) | 1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  // raised cosine weight at table index k
  function automatic longint unsigned cos_weight(longint unsigned k, longint unsigned base,
                                                 longint unsigned wt);
    longint unsigned x, x2, t, p, v, d;
    bit neg;
    int j;
    neg = 1'b0;
    if (2 * k > COS_DEPTH) begin
      k = COS_DEPTH - k;
      neg = 1'b1;
    end
    x = rdiv(k * PI_Q30, COS_DEPTH);
    x2 = (x * x + Q30_ONE / 2) >> 30;
    t = Q30_ONE;
    for (j = 7; j >= 1; j--) begin
      p = ((x2 * t) >> 30) / longint'((2 * j) * (2 * j - 1));
      t = (p >= Q30_ONE) ? 0 : Q30_ONE - p;
    end
    v = base * Q30_ONE;
    d = wt * t;
    if (neg) begin
      v = v + d;
    end else begin
      v = (v > d) ? v - d : 0;
    end
    return rdiv(v * 65536, 100 * Q30_ONE);
  endfunction

  function automatic weight_t predict_weight(cfg_t c, pixel_t px);
    longint unsigned dx2, dy2, s, d, m, n2, lo, hi, val;
    weight_t r;
    dx2 = half_offset(clamp_side(px.col), clamp_side(c.image_width));
    dy2 = half_offset(clamp_side(px.row), clamp_side(c.image_height));
    s = dx2 * dx2 + dy2 * dy2;
    d = (c.diameter < 2) ? 2 : c.diameter;
    m = d - 1;
    val = 0;
    r.inside_res = (s <= m * m);
    r.bad_kind = (c.window_kind > KIND_TRIANGLE);
    if (!r.bad_kind && r.inside_res) begin
      n2 = (m << FRAC_BITS) - radius_q16(s);
      lo = m << FRAC_BITS;
      hi = (d + 1) << FRAC_BITS;
      case (c.window_kind)
        KIND_RECT: val = 65536;
        KIND_BARTLETT: val = rdiv(n2 * 65536, lo);
        KIND_HAMMING: val = cos_weight(rdiv(n2 * COS_DEPTH, lo), 54, 46);
        KIND_HANN: val = cos_weight(rdiv((n2 + (2 << FRAC_BITS)) * COS_DEPTH, hi), 50, 50);
        default: val = rdiv((n2 + (2 << FRAC_BITS)) * 65536, hi);
      endcase
      if (val > 65536) val = 65536;
    end
    r.window_value = VALUE_W'(val);
    return r;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= v;
    @(posedge clk);
  endtask

  task automatic drain();
    while (exp_weights.size() != 0) @(posedge clk);
  endtask

  // registers only change with nothing in flight
  task automatic apply_cfg(cfg_t c);
    pixel_valid <= 1'b0;
    drain();
    @(posedge clk);
    write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(c.image_width));
    write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(c.image_height));
    write_reg(CFG_DIAMETER, c.diameter);
    write_reg(CFG_WINDOW_KIND, CFG_DATA_W'(c.window_kind));
    wr_en <= 1'b0;
    cur_cfg = c;
  endtask

  task automatic send_pixel(pixel_t px, bit typed, weight_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel <= px;
    do @(posedge clk); while (!pixel_ready);
    exp_weights.push_back(typed ? w : predict_weight(cur_cfg, px));
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      weight_ready <= ($urandom_range(99) >= recv_idle_pct);
      if (weight_valid && weight_ready) begin
        if (exp_weights.size() == 0) begin
          $error("weight transfer with nothing expected: %0h", weight);
          mismatches++;
        end else begin
          weight_t e;
          e = exp_weights.pop_front();
          if (e.window_value !== weight.window_value) begin
            $error("window_value exp %0d got %0d", e.window_value, weight.window_value);
            mismatches++;
          end
          if (e.inside_res !== weight.inside_res) begin
            $error("inside_res exp %0b got %0b", e.inside_res, weight.inside_res);
            mismatches++;
          end
          if (e.bad_kind !== weight.bad_kind) begin
            $error("bad_kind exp %0b got %0b", e.bad_kind, weight.bad_kind);
            mismatches++;
          end
        end
      end
      if ((pixel_valid && pixel_ready) || (weight_valid && weight_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("circular_window_pixel_generator regression: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic cfg_t mk_cfg(int w, int h, int d, logic [KIND_W-1:0] k);
    cfg_t c;
    c.image_width = SIDE_W'(w);
    c.image_height = SIDE_W'(h);
    c.diameter = DIAM_W'(d);
    c.window_kind = k;
    return c;
  endfunction

  function automatic pixel_t mk_px(int col, int row);
    pixel_t p;
    p.col = SIDE_W'(col);
    p.row = SIDE_W'(row);
    return p;
  endfunction

  function automatic weight_t mk_w(int v, bit ins, bit bad);
    weight_t w;
    w.window_value = VALUE_W'(v);
    w.inside_res = ins;
    w.bad_kind = bad;
    return w;
  endfunction

  initial begin
    dir_row_t dir_tab[DIR_ROWS];
    cfg_t phase_cfg[RAND_PHASES];
    cfg_t c;
    pixel_t px;
    int i, n, wmax, hmax;

    mismatches = 0;
    quiet_cycles = 0;
    send_idle_pct = 33;
    recv_idle_pct = 81;
    cur_cfg = mk_cfg(512, 512, 512, KIND_HAMMING);

    // reset settings, then rectangle and invalid kinds with known answers
    dir_tab[0] = '{cur_cfg, mk_px(256, 256), 1'b0, '0};
    dir_tab[1] = '{cur_cfg, mk_px(1, 256), 1'b0, '0};
    dir_tab[2] = '{cur_cfg, mk_px(100, 300), 1'b0, '0};
    c = mk_cfg(512, 512, 512, KIND_RECT);
    dir_tab[3] = '{c, mk_px(256, 256), 1'b1, mk_w(65536, 1, 0)};
    dir_tab[4] = '{c, mk_px(1, 1), 1'b1, mk_w(0, 0, 0)};
    dir_tab[5] = '{c, mk_px(0, 0), 1'b1, mk_w(0, 0, 0)};
    dir_tab[6] = '{c, mk_px(8191, 8191), 1'b1, mk_w(0, 0, 0)};
    dir_tab[7] = '{c, mk_px(4096, 1), 1'b1, mk_w(0, 0, 0)};
    c = mk_cfg(512, 512, 512, 3'd5);
    dir_tab[8] = '{c, mk_px(256, 256), 1'b1, mk_w(0, 1, 1)};
    dir_tab[9] = '{c, mk_px(1, 1), 1'b1, mk_w(0, 0, 1)};
    c = mk_cfg(512, 512, 512, 3'd7);
    dir_tab[10] = '{c, mk_px(8191, 0), 1'b1, mk_w(0, 0, 1)};
    c = mk_cfg(9, 9, 9, KIND_BARTLETT);
    dir_tab[11] = '{c, mk_px(5, 5), 1'b0, '0};
    dir_tab[12] = '{c, mk_px(1, 5), 1'b0, '0};
    c = mk_cfg(9, 9, 9, KIND_HANN);
    dir_tab[13] = '{c, mk_px(5, 5), 1'b0, '0};
    dir_tab[14] = '{c, mk_px(2, 4), 1'b0, '0};
    c = mk_cfg(9, 9, 9, KIND_TRIANGLE);
    dir_tab[15] = '{c, mk_px(5, 5), 1'b0, '0};
    dir_tab[16] = '{c, mk_px(1, 5), 1'b0, '0};
    // diameter below two acts as two
    c = mk_cfg(3, 3, 1, KIND_RECT);
    dir_tab[17] = '{c, mk_px(2, 2), 1'b1, mk_w(65536, 1, 0)};
    c = mk_cfg(8191, 8191, 16383, KIND_HAMMING);
    dir_tab[18] = '{c, mk_px(4096, 4096), 1'b0, '0};
    dir_tab[19] = '{c, mk_px(1, 1), 1'b0, '0};

    phase_cfg[0] = mk_cfg(64, 48, 40, KIND_RECT);
    phase_cfg[1] = mk_cfg(33, 17, 30, KIND_BARTLETT);
    phase_cfg[2] = mk_cfg(4096, 4096, 8192, KIND_HAMMING);
    phase_cfg[3] = mk_cfg(1, 1, 2, KIND_HANN);
    phase_cfg[4] = mk_cfg(100, 80, 90, KIND_TRIANGLE);
    phase_cfg[5] = mk_cfg($urandom_range(1, 200), $urandom_range(1, 200),
                          $urandom_range(2, 300), KIND_W'($urandom_range(0, 4)));
    phase_cfg[6] = mk_cfg(8191, 5, 16383, 3'd6);
    phase_cfg[7] = mk_cfg(20, 20, 0, KIND_HAMMING);
    phase_cfg[8] = mk_cfg($urandom_range(1, 300), $urandom_range(1, 300),
                          $urandom_range(0, 400), KIND_W'($urandom_range(0, 7)));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < DIR_ROWS; i++) begin
      if (dir_tab[i].c != cur_cfg) apply_cfg(dir_tab[i].c);
      send_pixel(dir_tab[i].p, dir_tab[i].typed, dir_tab[i].w);
    end

    for (i = 0; i < RAND_PHASES; i++) begin
      apply_cfg(phase_cfg[i]);
      send_idle_pct = (i < 3) ? 33 : (i < 6) ? 81 : 0;
      recv_idle_pct = (i < 3) ? 81 : (i < 6) ? 33 : 0;
      wmax = int'(clamp_side(phase_cfg[i].image_width));
      hmax = int'(clamp_side(phase_cfg[i].image_height));
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // mostly pixels inside the image, the rest any 13-bit value
        if ($urandom_range(99) < 80) begin
          px = mk_px($urandom_range(1, wmax), $urandom_range(1, hmax));
        end else begin
          px.col = SIDE_W'($urandom);
          px.row = SIDE_W'($urandom);
        end
        send_pixel(px, 1'b0, '0);
      end
    end
    pixel_valid <= 1'b0;

    drain();
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("circular_window_pixel_generator regression: pass");
    end else begin
      $display("circular_window_pixel_generator regression: fail");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/cwpg_pkg.sv
rtl/core/cwpg_front.sv
rtl/core/cwpg_queue.sv
rtl/core/cwpg_back.sv
rtl/core/circular_window_pixel_generator.sv
verif/tb_top.sv
